>>> hdl/bfsp_pkg.sv
package bfsp_pkg;

   // default sizes of the stores
   localparam int MAX_VERTICES_DEF = 64;
   localparam int MAX_EDGES_DEF    = 256;
   localparam int WEIGHT_BITS_DEF  = 16;

   // transaction field widths
   localparam int VERTEX_FIELD_BITS = 6;
   localparam int WEIGHT_FIELD_BITS = 16;
   localparam int DIST_FIELD_BITS   = 22;
   localparam int COUNT_REG_BITS    = 7;

   // register port
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 7;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_VERTEX_COUNT  = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SOURCE_VERTEX = 1'd1;
   localparam logic [COUNT_REG_BITS-1:0]    VERTEX_COUNT_RESET  = 7'd64;
   localparam logic [VERTEX_FIELD_BITS-1:0] SOURCE_VERTEX_RESET = 6'd0;

   // saturation bounds of the distance field
   localparam int DIST_OUT_MAX = 2097151;
   localparam int DIST_OUT_MIN = -2097152;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_INIT,
      ST_RUN,
      ST_DRAIN,
      ST_OUT_RD,
      ST_OUT_LD,
      ST_OUT_WAIT
   } state_type;

   typedef struct packed {
      logic valid;
      logic check;
   } relax_ctl_type;

   typedef struct packed {
      logic busy;
      logic write;
      logic relaxed;
   } relax_stat_type;

   function automatic int addr_bits(input int depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

   // wide enough that no distance can wrap during a run
   function automatic int dist_bits(input int max_vertices, input int max_edges,
                                    input int weight_bits);
      return weight_bits + $clog2(max_vertices) + $clog2(max_edges + 1) + 2;
   endfunction

endpackage

>>> hdl/bfsp_ifs.sv
interface bfsp_req_if;
   logic                                          valid;
   logic                                          ready;
   logic [bfsp_pkg::VERTEX_FIELD_BITS-1:0]        from_vertex;
   logic [bfsp_pkg::VERTEX_FIELD_BITS-1:0]        to_vertex;
   logic signed [bfsp_pkg::WEIGHT_FIELD_BITS-1:0] edge_weight;
   logic                                          last_edge;

   modport source (output valid, from_vertex, to_vertex, edge_weight, last_edge,
                   input ready);
   modport sink (input valid, from_vertex, to_vertex, edge_weight, last_edge,
                 output ready);
endinterface

interface bfsp_rsp_if;
   logic                                        valid;
   logic                                        ready;
   logic [bfsp_pkg::VERTEX_FIELD_BITS-1:0]      vertex_index;
   logic signed [bfsp_pkg::DIST_FIELD_BITS-1:0] distance;
   logic                                        reachable;
   logic                                        negative_cycle;
   logic                                        last_result;

   modport source (output valid, vertex_index, distance, reachable, negative_cycle,
                   last_result, input ready);
   modport sink (input valid, vertex_index, distance, reachable, negative_cycle,
                 last_result, output ready);
endinterface

interface bfsp_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [bfsp_pkg::CSR_INDEX_BITS-1:0]  index;
   logic [bfsp_pkg::CSR_DATA_BITS-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/bellman_ford_shortest_paths_unit.sv
// channel  dir  transaction     payload
// req_ch   in   edge            from_vertex, to_vertex, edge_weight, last_edge
// rsp_ch   out  vertex result   vertex_index, distance, reachable, negative_cycle, last_result
// csr_ch   in   register write  index, data
//
// edges load one per cycle; the edge marked last is followed by a solve of
// n passes over the E stored edges (n = effective vertex count, the last pass
// checking for a negative cycle), one edge relaxation per cycle through the
// distance memory; it opens with a sweep over the n vertices that rewrites the
// distance memory; results, or one negative-cycle flag, then leave one at a time, each held until taken
// req_ch.ready is low from the last edge until the final result is taken;
// reset returns to edge loading with an empty edge store
module bellman_ford_shortest_paths_unit #(
   parameter int MAX_VERTICES = bfsp_pkg::MAX_VERTICES_DEF,
   parameter int MAX_EDGES    = bfsp_pkg::MAX_EDGES_DEF,
   parameter int WEIGHT_BITS  = bfsp_pkg::WEIGHT_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   bfsp_csr_if.sink   csr_ch,
   bfsp_req_if.sink   req_ch,
   bfsp_rsp_if.source rsp_ch
);

   localparam int VB   = bfsp_pkg::addr_bits(MAX_VERTICES);
   localparam int CW   = $clog2(MAX_VERTICES + 1);
   localparam int PW   = bfsp_pkg::addr_bits(MAX_EDGES);
   localparam int EW   = $clog2(MAX_EDGES + 1);
   localparam int DB   = bfsp_pkg::dist_bits(MAX_VERTICES, MAX_EDGES, WEIGHT_BITS);
   localparam int FW   = bfsp_pkg::VERTEX_FIELD_BITS;
   localparam int OW   = bfsp_pkg::DIST_FIELD_BITS;
   // common width for comparing fields, registers and counts
   localparam int CMPW = (CW > bfsp_pkg::COUNT_REG_BITS) ? CW : bfsp_pkg::COUNT_REG_BITS;
   localparam int SW   = (DB > OW) ? DB : OW;
   localparam logic signed [SW-1:0] SAT_HI = SW'(bfsp_pkg::DIST_OUT_MAX);
   localparam logic signed [SW-1:0] SAT_LO = SW'(bfsp_pkg::DIST_OUT_MIN);

   // configuration registers
   logic [bfsp_pkg::COUNT_REG_BITS-1:0] vcount_ff;
   logic [FW-1:0]                       source_ff;

   // control state
   bfsp_pkg::state_type     state_ff, state_in;
   logic [EW-1:0]           edge_count_ff, edge_count_in;
   logic [PW-1:0]           ptr_ff, ptr_in;
   logic [CW-1:0]           pass_ff, pass_in;
   logic [CW-1:0]           vidx_ff, vidx_in;
   bfsp_pkg::relax_ctl_type s1_ctl_ff, s1_ctl_in;
   logic                    cyc_ff, cyc_in;

   // result register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [FW-1:0]           rsp_vertex_ff, rsp_vertex_in;
   logic signed [OW-1:0]    rsp_dist_ff, rsp_dist_in;
   logic                    rsp_reach_ff, rsp_reach_in;
   logic                    rsp_neg_ff, rsp_neg_in;
   logic                    rsp_last_ff, rsp_last_in;

   // decoded controls
   logic req_ready;
   logic init_wr;
   logic issue;
   logic out_rd;
   logic out_ld;

   logic [CMPW-1:0]        vc_w;
   logic [CMPW-1:0]        n_w;
   logic [CW-1:0]          n_c;
   logic                   req_acc;
   logic                   rsp_acc;
   logic                   edge_ok;
   logic                   vidx_last;
   logic                   ptr_last;
   logic                   pass_last;
   logic                   pipe_empty;
   logic [WEIGHT_BITS-1:0] req_weight;

   // edge store read side
   logic [VB-1:0]          e_tail;
   logic [VB-1:0]          e_head;
   logic [WEIGHT_BITS-1:0] e_weight;

   // distance store ports
   logic                   d_wr_en;
   logic [VB-1:0]          d_wr_addr;
   logic                   d_wr_reach;
   logic signed [DB-1:0]   d_wr_dist;
   logic [VB-1:0]          d_rd_a_addr;
   logic                   d_a_reach;
   logic signed [DB-1:0]   d_a_dist;
   logic                   d_b_reach;
   logic signed [DB-1:0]   d_b_dist;

   bfsp_pkg::relax_stat_type relax_stat;
   logic [VB-1:0]            relax_addr;
   logic signed [DB-1:0]     relax_dist;

   logic signed [SW-1:0]     out_ext;
   logic signed [SW-1:0]     out_sat;

   // effective vertex count: zero acts as one, clipped at the store depth
   assign vc_w = CMPW'(vcount_ff);
   assign n_w  = (vc_w == '0) ? CMPW'(1) :
                 ((vc_w > CMPW'(MAX_VERTICES)) ? CMPW'(MAX_VERTICES) : vc_w);
   assign n_c  = CW'(n_w);

   assign req_acc = req_ch.valid && req_ch.ready;
   assign rsp_acc = rsp_valid_ff && rsp_ch.ready;

   // out-of-range edges and edges past capacity are dropped at load
   assign edge_ok = (CMPW'(req_ch.from_vertex) < n_w) && (CMPW'(req_ch.to_vertex) < n_w) &&
                    (edge_count_ff < EW'(MAX_EDGES));

   assign vidx_last  = (vidx_ff == (n_c - CW'(1)));
   assign ptr_last   = (EW'(ptr_ff) == (edge_count_ff - EW'(1)));
   assign pass_last  = (pass_ff == (n_c - CW'(1)));
   assign pipe_empty = !s1_ctl_ff.valid && !relax_stat.busy;

   // weight is signed at bit WEIGHT_BITS-1 of the field; a wider weight is zero-extended
   if (WEIGHT_BITS <= bfsp_pkg::WEIGHT_FIELD_BITS) begin : g_weight_narrow
      assign req_weight = req_ch.edge_weight[WEIGHT_BITS-1:0];
   end else begin : g_weight_wide
      assign req_weight = WEIGHT_BITS'($unsigned(req_ch.edge_weight));
   end

   // register port, always ready
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= bfsp_pkg::VERTEX_COUNT_RESET;
         source_ff <= bfsp_pkg::SOURCE_VERTEX_RESET;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            bfsp_pkg::CSR_VERTEX_COUNT: begin
               vcount_ff <= csr_ch.data[bfsp_pkg::COUNT_REG_BITS-1:0];
            end
            bfsp_pkg::CSR_SOURCE_VERTEX: begin
               source_ff <= csr_ch.data[FW-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bfsp_pkg::ST_LOAD: begin
            if (req_acc && req_ch.last_edge) state_in = bfsp_pkg::ST_INIT;
         end
         bfsp_pkg::ST_INIT: begin
            if (vidx_last) begin
               state_in = (edge_count_ff == '0) ? bfsp_pkg::ST_DRAIN : bfsp_pkg::ST_RUN;
            end
         end
         bfsp_pkg::ST_RUN: begin
            if (ptr_last && pass_last) state_in = bfsp_pkg::ST_DRAIN;
         end
         bfsp_pkg::ST_DRAIN: begin
            if (pipe_empty) begin
               state_in = cyc_ff ? bfsp_pkg::ST_OUT_WAIT : bfsp_pkg::ST_OUT_RD;
            end
         end
         bfsp_pkg::ST_OUT_RD: begin
            state_in = bfsp_pkg::ST_OUT_LD;
         end
         bfsp_pkg::ST_OUT_LD: begin
            state_in = bfsp_pkg::ST_OUT_WAIT;
         end
         bfsp_pkg::ST_OUT_WAIT: begin
            if (rsp_acc) state_in = rsp_last_ff ? bfsp_pkg::ST_LOAD : bfsp_pkg::ST_OUT_RD;
         end
         default: begin
            state_in = bfsp_pkg::ST_LOAD;
         end
      endcase
   end

   // state decodes
   always_comb begin
      req_ready = 1'b0;
      init_wr   = 1'b0;
      issue     = 1'b0;
      out_rd    = 1'b0;
      out_ld    = 1'b0;
      case (state_ff)
         bfsp_pkg::ST_LOAD:   req_ready = 1'b1;
         bfsp_pkg::ST_INIT:   init_wr   = 1'b1;
         bfsp_pkg::ST_RUN:    issue     = 1'b1;
         bfsp_pkg::ST_OUT_RD: out_rd    = 1'b1;
         bfsp_pkg::ST_OUT_LD: out_ld    = 1'b1;
         default: begin
         end
      endcase
   end

   assign req_ch.ready = req_ready;

   // counters, pass control and negative cycle flag
   always_comb begin
      edge_count_in = edge_count_ff;
      ptr_in        = '0;
      pass_in       = '0;
      vidx_in       = vidx_ff;
      cyc_in        = cyc_ff | relax_stat.relaxed;

      if (req_acc && edge_ok) edge_count_in = edge_count_ff + EW'(1);
      if (rsp_acc && rsp_last_ff) edge_count_in = '0;

      if (issue) begin
         ptr_in  = ptr_last ? '0 : (ptr_ff + PW'(1));
         pass_in = ptr_last ? (pass_ff + CW'(1)) : pass_ff;
      end

      if (req_ready) vidx_in = '0;
      if (init_wr) begin
         vidx_in = vidx_last ? '0 : (vidx_ff + CW'(1));
         cyc_in  = 1'b0;
      end
      if (rsp_acc) vidx_in = vidx_ff + CW'(1);

      s1_ctl_in.valid = issue;
      s1_ctl_in.check = pass_last;
   end

   // saturate the stored distance into the result field
   always_comb begin
      out_ext = SW'(d_a_dist);
      if (out_ext > SAT_HI) begin
         out_sat = SAT_HI;
      end else if (out_ext < SAT_LO) begin
         out_sat = SAT_LO;
      end else begin
         out_sat = out_ext;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_vertex_in = rsp_vertex_ff;
      rsp_dist_in   = rsp_dist_ff;
      rsp_reach_in  = rsp_reach_ff;
      rsp_neg_in    = rsp_neg_ff;
      rsp_last_in   = rsp_last_ff;
      if (out_ld) begin
         rsp_valid_in  = 1'b1;
         rsp_vertex_in = FW'(vidx_ff);
         rsp_dist_in   = d_a_reach ? OW'(out_sat) : '0;
         rsp_reach_in  = d_a_reach;
         rsp_neg_in    = 1'b0;
         rsp_last_in   = vidx_last;
      end else if ((state_ff == bfsp_pkg::ST_DRAIN) && pipe_empty && cyc_ff) begin
         // single result flagging the cycle
         rsp_valid_in  = 1'b1;
         rsp_vertex_in = '0;
         rsp_dist_in   = '0;
         rsp_reach_in  = 1'b0;
         rsp_neg_in    = 1'b1;
         rsp_last_in   = 1'b1;
      end else if (rsp_acc) begin
         rsp_valid_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= bfsp_pkg::ST_LOAD;
         edge_count_ff <= '0;
         ptr_ff        <= '0;
         pass_ff       <= '0;
         vidx_ff       <= '0;
         s1_ctl_ff     <= '0;
         cyc_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         edge_count_ff <= edge_count_in;
         ptr_ff        <= ptr_in;
         pass_ff       <= pass_in;
         vidx_ff       <= vidx_in;
         s1_ctl_ff     <= s1_ctl_in;
         cyc_ff        <= cyc_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_vertex_ff <= rsp_vertex_in;
      rsp_dist_ff   <= rsp_dist_in;
      rsp_reach_ff  <= rsp_reach_in;
      rsp_neg_ff    <= rsp_neg_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.vertex_index   = rsp_vertex_ff;
   assign rsp_ch.distance       = rsp_dist_ff;
   assign rsp_ch.reachable      = rsp_reach_ff;
   assign rsp_ch.negative_cycle = rsp_neg_ff;
   assign rsp_ch.last_result    = rsp_last_ff;

   // edge memory: appended at load, streamed once per relaxation pass
   bfsp_edge_store #(
      .MAX_EDGES   (MAX_EDGES),
      .VERTEX_BITS (VB),
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_edge_store (
      .clock     (clock),
      .wr_en     (req_acc && edge_ok),
      .wr_addr   (PW'(edge_count_ff)),
      .wr_tail   (VB'(req_ch.from_vertex)),
      .wr_head   (VB'(req_ch.to_vertex)),
      .wr_weight (req_weight),
      .rd_addr   (ptr_ff),
      .rd_tail   (e_tail),
      .rd_head   (e_head),
      .rd_weight (e_weight)
   );

   // distance memory: swept at solve start, then relax writes, then result reads
   assign d_wr_en     = init_wr || relax_stat.write;
   assign d_wr_addr   = init_wr ? VB'(vidx_ff) : relax_addr;
   assign d_wr_reach  = init_wr ? (CMPW'(vidx_ff) == CMPW'(source_ff)) : 1'b1;
   assign d_wr_dist   = init_wr ? '0 : relax_dist;
   assign d_rd_a_addr = out_rd ? VB'(vidx_ff) : e_tail;

   bfsp_dist_store #(
      .MAX_VERTICES (MAX_VERTICES),
      .DIST_BITS    (DB)
   ) u_dist_store (
      .clock      (clock),
      .wr_en      (d_wr_en),
      .wr_addr    (d_wr_addr),
      .wr_reach   (d_wr_reach),
      .wr_dist    (d_wr_dist),
      .rd_a_addr  (d_rd_a_addr),
      .rd_b_addr  (e_head),
      .rd_a_reach (d_a_reach),
      .rd_a_dist  (d_a_dist),
      .rd_b_reach (d_b_reach),
      .rd_b_dist  (d_b_dist)
   );

   // relax stage: one edge per cycle, forwards the previous write
   bfsp_relax #(
      .MAX_VERTICES (MAX_VERTICES),
      .WEIGHT_BITS  (WEIGHT_BITS),
      .DIST_BITS    (DB)
   ) u_relax (
      .clock      (clock),
      .reset      (reset),
      .s1_ctl     (s1_ctl_ff),
      .s1_tail    (e_tail),
      .s1_head    (e_head),
      .s1_weight  (e_weight),
      .vcount     (n_c),
      .tail_reach (d_a_reach),
      .tail_dist  (d_a_dist),
      .head_reach (d_b_reach),
      .head_dist  (d_b_dist),
      .stat       (relax_stat),
      .wr_addr    (relax_addr),
      .wr_dist    (relax_dist)
   );

endmodule

>>> hdl/bfsp_edge_store.sv
module bfsp_edge_store #(
   parameter int MAX_EDGES   = bfsp_pkg::MAX_EDGES_DEF,
   parameter int VERTEX_BITS = bfsp_pkg::addr_bits(bfsp_pkg::MAX_VERTICES_DEF),
   parameter int WEIGHT_BITS = bfsp_pkg::WEIGHT_BITS_DEF
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [bfsp_pkg::addr_bits(MAX_EDGES)-1:0]    wr_addr,
   input  logic [VERTEX_BITS-1:0]                       wr_tail,
   input  logic [VERTEX_BITS-1:0]                       wr_head,
   input  logic [WEIGHT_BITS-1:0]                       wr_weight,
   input  logic [bfsp_pkg::addr_bits(MAX_EDGES)-1:0]    rd_addr,
   output logic [VERTEX_BITS-1:0]                       rd_tail,
   output logic [VERTEX_BITS-1:0]                       rd_head,
   output logic [WEIGHT_BITS-1:0]                       rd_weight
);

   localparam int EDGE_BITS = 2 * VERTEX_BITS + WEIGHT_BITS;

   logic [EDGE_BITS-1:0] mem [MAX_EDGES];
   logic [EDGE_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_tail, wr_head, wr_weight};
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign {rd_tail, rd_head, rd_weight} = rd_data_ff;

endmodule

>>> hdl/bfsp_dist_store.sv
module bfsp_dist_store #(
   parameter int MAX_VERTICES = bfsp_pkg::MAX_VERTICES_DEF,
   parameter int DIST_BITS    = bfsp_pkg::dist_bits(bfsp_pkg::MAX_VERTICES_DEF,
                                                    bfsp_pkg::MAX_EDGES_DEF,
                                                    bfsp_pkg::WEIGHT_BITS_DEF)
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [bfsp_pkg::addr_bits(MAX_VERTICES)-1:0]  wr_addr,
   input  logic                                          wr_reach,
   input  logic signed [DIST_BITS-1:0]                   wr_dist,
   input  logic [bfsp_pkg::addr_bits(MAX_VERTICES)-1:0]  rd_a_addr,
   input  logic [bfsp_pkg::addr_bits(MAX_VERTICES)-1:0]  rd_b_addr,
   output logic                                          rd_a_reach,
   output logic signed [DIST_BITS-1:0]                   rd_a_dist,
   output logic                                          rd_b_reach,
   output logic signed [DIST_BITS-1:0]                   rd_b_dist
);

   // reachable bit on top of the distance
   logic [DIST_BITS:0] mem [MAX_VERTICES];
   logic [DIST_BITS:0] rd_a_ff;
   logic [DIST_BITS:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_reach, wr_dist};
      end
      rd_a_ff <= mem[rd_a_addr];
      rd_b_ff <= mem[rd_b_addr];
   end

   assign rd_a_reach = rd_a_ff[DIST_BITS];
   assign rd_a_dist  = signed'(rd_a_ff[DIST_BITS-1:0]);
   assign rd_b_reach = rd_b_ff[DIST_BITS];
   assign rd_b_dist  = signed'(rd_b_ff[DIST_BITS-1:0]);

endmodule

>>> hdl/bfsp_relax.sv
module bfsp_relax #(
   parameter int MAX_VERTICES = bfsp_pkg::MAX_VERTICES_DEF,
   parameter int WEIGHT_BITS  = bfsp_pkg::WEIGHT_BITS_DEF,
   parameter int DIST_BITS    = bfsp_pkg::dist_bits(bfsp_pkg::MAX_VERTICES_DEF,
                                                    bfsp_pkg::MAX_EDGES_DEF,
                                                    bfsp_pkg::WEIGHT_BITS_DEF)
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  bfsp_pkg::relax_ctl_type                       s1_ctl,
   input  logic [bfsp_pkg::addr_bits(MAX_VERTICES)-1:0]  s1_tail,
   input  logic [bfsp_pkg::addr_bits(MAX_VERTICES)-1:0]  s1_head,
   input  logic [WEIGHT_BITS-1:0]                        s1_weight,
   input  logic [$clog2(MAX_VERTICES+1)-1:0]             vcount,
   input  logic                                          tail_reach,
   input  logic signed [DIST_BITS-1:0]                   tail_dist,
   input  logic                                          head_reach,
   input  logic signed [DIST_BITS-1:0]                   head_dist,
   output bfsp_pkg::relax_stat_type                      stat,
   output logic [bfsp_pkg::addr_bits(MAX_VERTICES)-1:0]  wr_addr,
   output logic signed [DIST_BITS-1:0]                   wr_dist
);

   localparam int VB = bfsp_pkg::addr_bits(MAX_VERTICES);
   localparam int CW = $clog2(MAX_VERTICES + 1);

   bfsp_pkg::relax_ctl_type     ctl_ff;
   logic [VB-1:0]               tail_ff;
   logic [VB-1:0]               head_ff;
   logic [WEIGHT_BITS-1:0]      weight_ff;
   logic                        in_range_ff;
   logic                        in_range_in;

   // last distance written, for the edge whose read overlapped that write
   logic                        fwd_valid_ff;
   logic [VB-1:0]               fwd_addr_ff;
   logic signed [DIST_BITS-1:0] fwd_dist_ff;

   logic                        t_reach;
   logic signed [DIST_BITS-1:0] t_dist;
   logic                        h_reach;
   logic signed [DIST_BITS-1:0] h_dist;
   logic signed [DIST_BITS-1:0] cand;
   logic                        hit;

   assign in_range_in = (CW'(s1_tail) < vcount) && (CW'(s1_head) < vcount);

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff       <= '0;
         fwd_valid_ff <= 1'b0;
      end else begin
         ctl_ff       <= s1_ctl;
         fwd_valid_ff <= stat.write;
      end
      tail_ff     <= s1_tail;
      head_ff     <= s1_head;
      weight_ff   <= s1_weight;
      in_range_ff <= in_range_in;
      fwd_addr_ff <= wr_addr;
      fwd_dist_ff <= wr_dist;
   end

   always_comb begin
      t_reach = tail_reach;
      t_dist  = tail_dist;
      h_reach = head_reach;
      h_dist  = head_dist;
      if (fwd_valid_ff && (fwd_addr_ff == tail_ff)) begin
         t_reach = 1'b1;
         t_dist  = fwd_dist_ff;
      end
      if (fwd_valid_ff && (fwd_addr_ff == head_ff)) begin
         h_reach = 1'b1;
         h_dist  = fwd_dist_ff;
      end
      cand = t_dist + DIST_BITS'($signed(weight_ff));
      hit  = ctl_ff.valid && in_range_ff && t_reach && (!h_reach || (cand < h_dist));
   end

   assign stat.busy    = ctl_ff.valid;
   assign stat.write   = hit && !ctl_ff.check;
   assign stat.relaxed = hit && ctl_ff.check;
   assign wr_addr      = head_ff;
   assign wr_dist      = cand;

endmodule

>>> hdl/bfsp_checker.sv
module bfsp_checker (
   input logic                                        clock,
   input logic                                        reset,
   input logic                                        req_valid,
   input logic                                        req_ready,
   input logic                                        req_last_edge,
   input logic                                        rsp_valid,
   input logic                                        rsp_ready,
   input logic [bfsp_pkg::VERTEX_FIELD_BITS-1:0]      rsp_vertex_index,
   input logic signed [bfsp_pkg::DIST_FIELD_BITS-1:0] rsp_distance,
   input logic                                        rsp_reachable,
   input logic                                        rsp_negative_cycle,
   input logic                                        rsp_last_result
);

   // a held result keeps its vertex, distance and last flag under backpressure
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_vertex_index) &&
      $stable(rsp_distance) && $stable(rsp_last_result))
      else $error("result changed while stalled");

   // no edge is taken while results are pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input ready while a result is pending");

   // an ordinary edge leaves the block loading
   a_plain_edge: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_last_edge |=> req_ready && !rsp_valid)
      else $error("ordinary edge did not keep loading");

   // cycle flag comes alone, as the final result
   a_neg_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_negative_cycle |-> rsp_last_result && !rsp_reachable &&
      (rsp_vertex_index == '0) && (rsp_distance == '0))
      else $error("malformed negative cycle result");

   // after the final result the block loads again
   a_back_to_load: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last_result |=> req_ready)
      else $error("not loading after final result");

endmodule

bind bellman_ford_shortest_paths_unit bfsp_checker u_bfsp_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_ch.valid),
   .req_ready          (req_ch.ready),
   .req_last_edge      (req_ch.last_edge),
   .rsp_valid          (rsp_ch.valid),
   .rsp_ready          (rsp_ch.ready),
   .rsp_vertex_index   (rsp_ch.vertex_index),
   .rsp_distance       (rsp_ch.distance),
   .rsp_reachable      (rsp_ch.reachable),
   .rsp_negative_cycle (rsp_ch.negative_cycle),
   .rsp_last_result    (rsp_ch.last_result)
);
